// File: sv/fconv_pkg.sv
// fconv_pkg: shared widths, command codes and controller/datapath bundles
// for the full linear convolution core. No dependencies.
package fconv_pkg;

  localparam int CMD_W   = 2;
  localparam int TIDX_W  = 4;
  localparam int VALUE_W = 16;
  localparam int PROD_W  = 32;
  localparam int RES_W   = 40;
  localparam int TCNT_W  = 5;

  localparam logic [TCNT_W-1:0] TCNT_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic kern_wr;
    logic smp_cap;
    logic hist_wr;
    logic hist_zero;
    logic mac_en;
    logic mac_first;
    logic fill_clr;
    logic out_load;
    logic out_last;
  } fconv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic out_free;
  } fconv_sts_t;

endpackage

// File: sv/fconv_in_if.sv
// fconv_in_if: request channel of the convolution core (valid/ready plus fields)
// depends on fconv_pkg
interface fconv_in_if;
  import fconv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [TIDX_W-1:0]         tap_index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output command, output tap_index, output value,
                  input ready);
  modport sink   (input valid, input command, input tap_index, input value,
                  output ready);
endinterface

// File: sv/fconv_out_if.sv
// fconv_out_if: result channel of the convolution core (valid/ready plus fields)
// depends on fconv_pkg
interface fconv_out_if;
  import fconv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result;
  logic                    last;

  modport source (output valid, output result, output last, input ready);
  modport sink   (input valid, input result, input last, output ready);
endinterface

// File: sv/full_linear_convolution_core.sv
// full_linear_convolution_core: streaming FIR giving the full linear convolution.
// Push: capture, delay line write, tap walk, drain and result load once the output is free;
// no new request until idle again. Flush: n-1 tail results (n = taps in use), each with the
// shared multiply-accumulate walking the taps one per cycle. Load and no-op requests stay idle.
// Synchronous active-low reset clears the fill count and kernel valid bits, tap_count = 16.
// Depends on fconv_pkg, fconv_in_if, fconv_out_if, fconv_ctrl, fconv_dp.
module full_linear_convolution_core #(
  parameter int TAPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fconv_in_if.sink                      in_req,
  fconv_out_if.source                   out_res,
  input  logic                          cfg_wr_en,
  input  logic [fconv_pkg::TCNT_W-1:0]  cfg_wr_data
);
  import fconv_pkg::*;

  localparam int AW = $clog2(TAPS);
  localparam int NW = $clog2(TAPS + 1);

  logic [TCNT_W-1:0] tap_count_r;
  logic [NW-1:0]     n_taps;
  fconv_cmd_t        cmd;
  fconv_sts_t        sts;
  logic [AW-1:0]     tap;
  logic              ctrl_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TCNT_RESET;
    end else if (cfg_wr_en) begin
      tap_count_r <= cfg_wr_data;
    end
  end

  // zero acts as one tap, anything above the built depth as the full depth
  always_comb begin
    priority if (tap_count_r == '0) begin
      n_taps = NW'(1);
    end else if (int'(tap_count_r) > TAPS) begin
      n_taps = NW'(TAPS);
    end else begin
      n_taps = NW'(tap_count_r);
    end
  end

  assign in_req.ready = ctrl_ready;

  fconv_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_ready   (ctrl_ready),
    .in_command (in_req.command),
    .n_taps     (n_taps),
    .sts        (sts),
    .cmd        (cmd),
    .tap        (tap)
  );

  fconv_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .tap          (tap),
    .in_tap_index (in_req.tap_index),
    .in_value     (in_req.value),
    .sts          (sts),
    .out_valid    (out_res.valid),
    .out_ready    (out_res.ready),
    .out_result   (out_res.result),
    .out_last     (out_res.last)
  );

endmodule

// File: sv/fconv_dp.sv
// fconv_dp: datapath - circular delay line memory, kernel memory with valid
// bits, pipelined multiply-accumulate and the result register. Uses fconv_pkg.
module fconv_dp #(
  parameter int TAPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fconv_pkg::fconv_cmd_t               cmd,
  input  logic [$clog2(TAPS)-1:0]             tap,
  input  logic [fconv_pkg::TIDX_W-1:0]        in_tap_index,
  input  logic signed [fconv_pkg::VALUE_W-1:0] in_value,
  output fconv_pkg::fconv_sts_t               sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fconv_pkg::RES_W-1:0]  out_result,
  output logic                                out_last
);
  import fconv_pkg::*;

  localparam int AW = $clog2(TAPS);
  localparam int NW = $clog2(TAPS + 1);

  logic [VALUE_W-1:0] hist_mem [TAPS];
  logic [VALUE_W-1:0] kern_mem [TAPS];
  logic [TAPS-1:0]    kvalid_r;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [NW-1:0] fill_r;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   rd_wrap;
  logic          kern_hit;

  logic signed [VALUE_W-1:0] smp_r;
  logic signed [VALUE_W-1:0] hist_wdata;

  logic signed [VALUE_W-1:0] hist_rd_r, kern_rd_r;
  logic                      v1_r, first1_r, hv1_r, kv1_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      v2_r, first2_r;
  logic signed [RES_W-1:0]   acc_r;
  logic signed [RES_W-1:0]   prod_ext;

  logic                      out_valid_r;
  logic signed [RES_W-1:0]   result_r;
  logic                      last_r;

  assign wp_nxt     = (wp_r == AW'(TAPS - 1)) ? '0 : wp_r + AW'(1);
  assign hist_wdata = cmd.hist_zero ? '0 : smp_r;
  assign kern_hit   = int'(in_tap_index) < TAPS;

  // newest sample sits at wp_r, tap k lies k entries behind it
  assign rd_wrap = {1'b0, wp_r} + (AW + 1)'(TAPS) - {1'b0, tap};
  assign rd_addr = (wp_r >= tap) ? wp_r - tap : rd_wrap[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.smp_cap) begin
      smp_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_wr) begin
      hist_mem[wp_nxt] <= hist_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kern_wr && kern_hit) begin
      kern_mem[AW'(in_tap_index)] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    hist_rd_r <= hist_mem[rd_addr];
    kern_rd_r <= kern_mem[tap];
    first1_r  <= cmd.mac_first;
    hv1_r     <= NW'(tap) < fill_r;
    kv1_r     <= kvalid_r[tap];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      fill_r   <= '0;
      kvalid_r <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      v1_r <= cmd.mac_en;
      v2_r <= v1_r;
      if (cmd.hist_wr) begin
        wp_r <= wp_nxt;
      end
      priority if (cmd.fill_clr) begin
        fill_r <= '0;
      end else if (cmd.hist_wr && fill_r != NW'(TAPS)) begin
        fill_r <= fill_r + NW'(1);
      end
      if (cmd.kern_wr && kern_hit) begin
        kvalid_r[AW'(in_tap_index)] <= 1'b1;
      end
    end
  end

  // unwritten or out-of-window entries contribute zero
  always_ff @(posedge clk) begin
    prod_r   <= (hv1_r && kv1_r) ? PROD_W'(hist_rd_r * kern_rd_r) : '0;
    first2_r <= first1_r;
  end

  assign prod_ext = {{(RES_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= first2_r ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_r <= acc_r;
      last_r   <= cmd.out_last;
    end
  end

  assign sts.busy     = v1_r || v2_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_result = result_r;
  assign out_last   = last_r;

  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !v1_r && !v2_r)
    else $error("result loaded while accumulation still in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= TAPS)
    else $error("delay line fill count beyond depth");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result register became valid without a load");

endmodule

// File: sv/fconv_ctrl.sv
// fconv_ctrl: controller state machine - decodes requests, walks the taps
// through the shared multiply-accumulate and sequences flush tails. Uses fconv_pkg.
module fconv_ctrl #(
  parameter int TAPS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fconv_pkg::CMD_W-1:0]    in_command,
  input  logic [$clog2(TAPS+1)-1:0]      n_taps,
  input  fconv_pkg::fconv_sts_t          sts,
  output fconv_pkg::fconv_cmd_t          cmd,
  output logic [$clog2(TAPS)-1:0]        tap
);
  import fconv_pkg::*;

  localparam int AW = $clog2(TAPS);
  localparam int NW = $clog2(TAPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [NW-1:0] k_r, k_nxt;
  logic [NW-1:0] remain_r, remain_nxt;
  logic          tail_r, tail_nxt;
  logic          accept;
  logic          k_end;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_ready = (state_r == ST_IDLE);
  assign tap      = k_r[AW-1:0];
  assign k_end    = (k_r == n_taps - NW'(1));

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    remain_nxt = remain_r;
    tail_nxt   = tail_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_LOAD: begin
              cmd.kern_wr = 1'b1;
            end
            CMD_PUSH: begin
              cmd.smp_cap = 1'b1;
              tail_nxt    = 1'b0;
              state_nxt   = ST_WRITE;
            end
            CMD_FLUSH: begin
              // a single tap has no tail, only the delay line clears
              if (n_taps == NW'(1)) begin
                cmd.fill_clr = 1'b1;
              end else begin
                remain_nxt = n_taps - NW'(1);
                tail_nxt   = 1'b1;
                state_nxt  = ST_WRITE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WRITE: begin
        cmd.hist_wr   = 1'b1;
        cmd.hist_zero = tail_r;
        k_nxt         = '0;
        state_nxt     = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd.mac_en    = 1'b1;
        cmd.mac_first = (k_r == '0);
        if (k_end) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + NW'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = tail_r && (remain_r == NW'(1));
          priority if (tail_r && remain_r != NW'(1)) begin
            remain_nxt = remain_r - NW'(1);
            state_nxt  = ST_WRITE;
          end else if (tail_r) begin
            cmd.fill_clr = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      remain_r <= '0;
      tail_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      remain_r <= remain_nxt;
      tail_r   <= tail_nxt;
    end
  end

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded into an occupied output register");

  a_clear_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_clr |-> !sts.busy && !cmd.hist_wr)
    else $error("delay line cleared during accumulation");

  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_en |-> k_r < n_taps)
    else $error("tap walk beyond taps in use");

  a_tail_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && cmd.out_load && tail_r && !cmd.out_last
      |=> (state_r == ST_WRITE) && (remain_r == $past(remain_r) - NW'(1)))
    else $error("flush tail count did not step");

endmodule
